>>> src/pola_pkg.sv
`default_nettype none

package pola_pkg;

   // result and request field widths
   localparam int ID_W     = 8;
   localparam int STATUS_W = 2;
   localparam int WAIT_W   = 32;
   localparam int OCC_W    = 5;
   localparam int CMD_W    = 2;
   localparam int PRIO_IN_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_REQUEST = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_TICK    = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED   = 2'd0,
      ST_FULL      = 2'd1,
      ST_NO_HOLDER = 2'd2
   } status_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   granted_id;
      logic [WAIT_W-1:0] wait_ticks;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/pola_queue.sv
`default_nettype none

module pola_queue #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 42
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/pola_alu.sv
`default_nettype none

// shared subtract and magnitude compare
module pola_alu #(
   parameter int WIDTH = 32
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   output logic [WIDTH-1:0] diff,
   output logic             a_gt_b
);

   assign diff   = op_a - op_b;
   assign a_gt_b = (op_a > op_b);

endmodule

`default_nettype wire

>>> src/pola_ctrl.sv
`default_nettype none

module pola_ctrl #(
   parameter int QUEUE_DEPTH     = 16,
   parameter int PRIORITY_LEVELS = 4,
   parameter int TIME_BITS       = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [pola_pkg::CMD_W-1:0]         req_command,
   input  logic [pola_pkg::ID_W-1:0]          req_requester_id,
   input  logic [pola_pkg::PRIO_IN_W-1:0]     req_priority_req,
   output logic                               res_valid,
   input  logic                               res_ready,
   output pola_pkg::rsp_type                  res_data
);

   import pola_pkg::*;

   localparam int PW = $clog2(PRIORITY_LEVELS);
   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = ID_W + PW + TIME_BITS;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_INS_RD   = 7'b0000010,
      S_INS_CMP  = 7'b0000100,
      S_REL_HEAD = 7'b0001000,
      S_REL_RD   = 7'b0010000,
      S_REL_WR   = 7'b0100000,
      S_OUT      = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic                 held_ff, held_in;
   logic [CW-1:0]        waiters_ff, waiters_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [PW-1:0]        prio_ff, prio_in;
   rsp_type              res_ff, res_in;

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [EW-1:0]        mem_wdata;
   logic [AW-1:0]        mem_raddr;
   logic [EW-1:0]        mem_rdata;

   logic [TIME_BITS-1:0] alu_a, alu_b, alu_diff;
   logic                 alu_gt;

   logic [ID_W-1:0]      rd_id;
   logic [PW-1:0]        rd_prio;
   logic [TIME_BITS-1:0] rd_time;
   logic [PW-1:0]        prio_sat;
   logic [CW-1:0]        idx_dec, idx_inc;
   logic [OCC_W-1:0]     occ_now;
   logic [EW-1:0]        new_entry;

   pola_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (EW)
   ) u_queue (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   pola_alu #(
      .WIDTH (TIME_BITS)
   ) u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .diff   (alu_diff),
      .a_gt_b (alu_gt)
   );

   assign rd_id     = mem_rdata[EW-1 -: ID_W];
   assign rd_prio   = mem_rdata[TIME_BITS +: PW];
   assign rd_time   = mem_rdata[TIME_BITS-1:0];
   assign idx_dec   = idx_ff - CW'(1);
   assign idx_inc   = idx_ff + CW'(1);
   assign occ_now   = OCC_W'(waiters_ff) + OCC_W'(held_ff);
   assign new_entry = {id_ff, prio_ff, time_ff};

   // levels above the top one fold onto the lowest priority
   always_comb begin
      if (int'(req_priority_req) > PRIORITY_LEVELS - 1) begin
         prio_sat = PW'(PRIORITY_LEVELS - 1);
      end else begin
         prio_sat = PW'(req_priority_req);
      end
   end

   always_comb begin
      state_in   = state_ff;
      held_in    = held_ff;
      waiters_in = waiters_ff;
      time_in    = time_ff;
      idx_in     = idx_ff;
      id_in      = id_ff;
      prio_in    = prio_ff;
      res_in     = res_ff;
      mem_we     = 1'b0;
      mem_waddr  = idx_ff[AW-1:0];
      mem_wdata  = new_entry;
      mem_raddr  = '0;
      alu_a      = time_ff;
      alu_b      = rd_time;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_command)
                  CMD_REQUEST: begin
                     if (!held_ff && waiters_ff == '0) begin
                        held_in           = 1'b1;
                        res_in.status     = ST_GRANTED;
                        res_in.granted_id = req_requester_id;
                        res_in.wait_ticks = '0;
                        res_in.occupancy  = OCC_W'(1);
                        state_in          = S_OUT;
                     end else if (waiters_ff == CW'(QUEUE_DEPTH)) begin
                        res_in.status     = ST_FULL;
                        res_in.granted_id = '0;
                        res_in.wait_ticks = '0;
                        res_in.occupancy  = occ_now;
                        state_in          = S_OUT;
                     end else begin
                        id_in    = req_requester_id;
                        prio_in  = prio_sat;
                        idx_in   = waiters_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  CMD_RELEASE: begin
                     if (!held_ff) begin
                        res_in.status     = ST_NO_HOLDER;
                        res_in.granted_id = '0;
                        res_in.wait_ticks = '0;
                        res_in.occupancy  = occ_now;
                        state_in          = S_OUT;
                     end else if (waiters_ff == '0) begin
                        held_in = 1'b0;
                     end else begin
                        mem_raddr = '0;
                        idx_in    = '0;
                        state_in  = S_REL_HEAD;
                     end
                  end
                  CMD_TICK: begin
                     time_in = time_ff + TIME_BITS'(1);
                  end
                  default: begin
                  end
               endcase
            end
         end

         // walk from the tail toward the head, moving less urgent waiters back a slot
         S_INS_RD: begin
            if (idx_ff == '0) begin
               mem_we     = 1'b1;
               mem_waddr  = '0;
               waiters_in = waiters_ff + CW'(1);
               state_in   = S_IDLE;
            end else begin
               mem_raddr = idx_dec[AW-1:0];
               state_in  = S_INS_CMP;
            end
         end

         S_INS_CMP: begin
            alu_a = TIME_BITS'(rd_prio);
            alu_b = TIME_BITS'(prio_ff);
            mem_we = 1'b1;
            if (alu_gt) begin
               mem_wdata = mem_rdata;
               idx_in    = idx_dec;
               state_in  = S_INS_RD;
            end else begin
               waiters_in = waiters_ff + CW'(1);
               state_in   = S_IDLE;
            end
         end

         // head entry is on the read port; wait is a modular time difference
         S_REL_HEAD: begin
            alu_a             = time_ff;
            alu_b             = rd_time;
            res_in.status     = ST_GRANTED;
            res_in.granted_id = rd_id;
            res_in.wait_ticks = WAIT_W'(alu_diff);
            res_in.occupancy  = OCC_W'(waiters_ff);
            state_in          = S_REL_RD;
         end

         S_REL_RD: begin
            if (idx_inc < waiters_ff) begin
               mem_raddr = idx_inc[AW-1:0];
               state_in  = S_REL_WR;
            end else begin
               waiters_in = waiters_ff - CW'(1);
               state_in   = S_OUT;
            end
         end

         S_REL_WR: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
            idx_in    = idx_inc;
            state_in  = S_REL_RD;
         end

         S_OUT: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         held_ff    <= 1'b0;
         waiters_ff <= '0;
         time_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         held_ff    <= held_in;
         waiters_ff <= waiters_in;
         time_ff    <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      id_ff   <= id_in;
      prio_ff <= prio_in;
      res_ff  <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_OUT);
   assign res_data  = res_ff;

   a_waiters_bound: assert property (@(posedge clock) disable iff (reset)
      waiters_ff <= CW'(QUEUE_DEPTH))
      else $error("waiter count beyond queue depth");

   a_waiters_need_holder: assert property (@(posedge clock) disable iff (reset)
      (waiters_ff != '0) |-> held_ff)
      else $error("waiters present with the lock free");

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == CMD_TICK)
      |=> (time_ff == $past(time_ff) + TIME_BITS'(1)))
      else $error("tick did not advance time");

   a_free_only_on_release: assert property (@(posedge clock) disable iff (reset)
      $fell(held_ff) |-> $past(req_valid && req_ready && req_command == CMD_RELEASE
                               && waiters_ff == '0))
      else $error("lock freed without a release on an empty queue");

endmodule

`default_nettype wire

>>> src/priority_ordered_lock_arbiter.sv
`default_nettype none

// single lock with a priority-sorted waiting queue (0 most urgent, fifo within a level)
// req channel: command (request, release, tick), requester id and priority;
//   a transfer happens when req_valid and req_ready are both high
// rsp channel: status, granted id, wait in ticks and occupancy; one transfer at most
//   per request or release, none for a queued request, an idle release or a tick
// steps, with the rsp register free: a tick and an idle release finish in idle; an
//   immediate grant or rejection goes to the output state; a queued request compares
//   waiters from the tail, moving each less urgent one back a slot; a release that
//   hands over reads the head, then moves each later waiter up a slot; the cost is set
//   by the one-read, one-write queue memory and the one shared compare/subtract unit
// a finished result is held in the sequencer's output state until the rsp register takes it
// the queue memory is not cleared: a fill count marks the valid prefix
// reset: synchronous, clears the lock, the waiter count and the tick counter
// a stalled receiver holds the result in the rsp register; the next item is still
//   taken and processed, and only a second result waits inside the sequencer
module priority_ordered_lock_arbiter #(
   parameter int QUEUE_DEPTH     = 16,
   parameter int PRIORITY_LEVELS = 4,
   parameter int TIME_BITS       = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [pola_pkg::CMD_W-1:0]      req_command,
   input  logic [pola_pkg::ID_W-1:0]       req_requester_id,
   input  logic [pola_pkg::PRIO_IN_W-1:0]  req_priority_req,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pola_pkg::STATUS_W-1:0]   rsp_status,
   output logic [pola_pkg::ID_W-1:0]       rsp_granted_id,
   output logic [pola_pkg::WAIT_W-1:0]     rsp_wait_ticks,
   output logic [pola_pkg::OCC_W-1:0]      rsp_occupancy
);

   import pola_pkg::*;

   logic    res_valid;
   logic    res_ready;
   rsp_type res_data;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // sequencer, queue memory and shared unit
   pola_ctrl #(
      .QUEUE_DEPTH     (QUEUE_DEPTH),
      .PRIORITY_LEVELS (PRIORITY_LEVELS),
      .TIME_BITS       (TIME_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_requester_id (req_requester_id),
      .req_priority_req (req_priority_req),
      .res_valid        (res_valid),
      .res_ready        (res_ready),
      .res_data         (res_data)
   );

   // output register takes a new result when empty or draining this cycle
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_data_ff.status;
   assign rsp_granted_id = rsp_data_ff.granted_id;
   assign rsp_wait_ticks = rsp_data_ff.wait_ticks;
   assign rsp_occupancy  = rsp_data_ff.occupancy;

endmodule

`default_nettype wire

>>> test/priority_ordered_lock_arbiter_tb.sv
module priority_ordered_lock_arbiter_tb;
   import pola_pkg::*;

   localparam int QUEUE_DEPTH   = 16;
   // a command code the block must ignore
   localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;
   // a silent item may still keep the sequencer busy for a full queue shift
   localparam int SETTLE_CYCLES = 48;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int PHASE_ITEMS   = 470;
   localparam int BIAS_BLOCK    = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int PRESSURE_ITEMS = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_command      = CMD_TICK;
   logic [ID_W-1:0]      req_requester_id = '0;
   logic [PRIO_IN_W-1:0] req_priority_req = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [ID_W-1:0]      rsp_granted_id;
   logic [WAIT_W-1:0]    rsp_wait_ticks;
   logic [OCC_W-1:0]     rsp_occupancy;

   priority_ordered_lock_arbiter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_requester_id (req_requester_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_id   (rsp_granted_id),
      .rsp_wait_ticks   (rsp_wait_ticks),
      .rsp_occupancy    (rsp_occupancy)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // idling knobs, percent per cycle
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   // long receiver hold-off, driven by its own process
   bit          rsp_hold      = 1'b0;
   int unsigned error_count   = 0;

   // outcomes predicted at each accepted transfer, oldest first
   rsp_type pending_outcomes [$];

   // --- shadow of the arbiter state ---
   bit               lock_owned   = 1'b0;
   int unsigned      waiter_total = 0;
   logic [ID_W-1:0]  waiter_id    [QUEUE_DEPTH];
   logic [1:0]       waiter_level [QUEUE_DEPTH];
   logic [WAIT_W-1:0] waiter_since [QUEUE_DEPTH];
   logic [OCC_W-1:0] holders_plus_waiters = '0;
   logic [WAIT_W-1:0] tick_count  = '0;

   // one step of the lock: returns 1 when the step yields a result transfer
   function automatic bit predict_lock_event(input logic [CMD_W-1:0] cmd,
                                             input logic [ID_W-1:0] id,
                                             input logic [PRIO_IN_W-1:0] prio,
                                             output rsp_type outcome);
      int unsigned slot;
      int unsigned i;
      logic [1:0]  level;
      outcome = '0;
      // a two-bit priority never exceeds the lowest level, so no saturation here
      level = prio;
      case (cmd)
         CMD_REQUEST: begin
            // free lock and nobody waiting: grant at once
            if (!lock_owned && waiter_total == 0) begin
               lock_owned = 1'b1;
               holders_plus_waiters = 5'd1;
               outcome.status     = ST_GRANTED;
               outcome.granted_id = id;
               outcome.occupancy  = holders_plus_waiters;
               return 1'b1;
            end
            if (waiter_total >= QUEUE_DEPTH) begin
               outcome.status    = ST_FULL;
               outcome.occupancy = holders_plus_waiters;
               return 1'b1;
            end
            // behind every waiter of equal or more urgent level
            slot = 0;
            while (slot < waiter_total && waiter_level[slot] <= level) slot++;
            for (i = waiter_total; i > slot; i--) begin
               waiter_id[i]    = waiter_id[i-1];
               waiter_level[i] = waiter_level[i-1];
               waiter_since[i] = waiter_since[i-1];
            end
            waiter_id[slot]    = id;
            waiter_level[slot] = level;
            waiter_since[slot] = tick_count;
            waiter_total++;
            holders_plus_waiters = OCC_W'(waiter_total + (lock_owned ? 1 : 0));
            return 1'b0;
         end
         CMD_RELEASE: begin
            if (!lock_owned) begin
               outcome.status    = ST_NO_HOLDER;
               outcome.occupancy = holders_plus_waiters;
               return 1'b1;
            end
            if (waiter_total == 0) begin
               lock_owned = 1'b0;
               holders_plus_waiters = '0;
               return 1'b0;
            end
            // hand over to the head, wait wraps modulo the tick width
            outcome.status     = ST_GRANTED;
            outcome.granted_id = waiter_id[0];
            outcome.wait_ticks = tick_count - waiter_since[0];
            for (i = 0; i + 1 < waiter_total; i++) begin
               waiter_id[i]    = waiter_id[i+1];
               waiter_level[i] = waiter_level[i+1];
               waiter_since[i] = waiter_since[i+1];
            end
            holders_plus_waiters = OCC_W'(waiter_total);
            waiter_total--;
            outcome.occupancy = holders_plus_waiters;
            return 1'b1;
         end
         CMD_TICK: begin
            tick_count = tick_count + 1'b1;
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endfunction

   task automatic check_outcome();
      rsp_type want;
      if (pending_outcomes.size() == 0) begin
         flag_error($sformatf("unexpected result: status %0d id %02h wait %0d occ %0d",
                              rsp_status, rsp_granted_id, rsp_wait_ticks, rsp_occupancy));
         return;
      end
      want = pending_outcomes.pop_front();
      if (rsp_status !== want.status || rsp_granted_id !== want.granted_id ||
          rsp_wait_ticks !== want.wait_ticks || rsp_occupancy !== want.occupancy)
         flag_error($sformatf(
            "result mismatch: expected status %0d id %02h wait %0d occ %0d, got %0d %02h %0d %0d",
            want.status, want.granted_id, want.wait_ticks, want.occupancy,
            rsp_status, rsp_granted_id, rsp_wait_ticks, rsp_occupancy));
   endtask

   // result side: sample at the edge, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) check_outcome();
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic hold_receiver(input int unsigned cycles);
      rsp_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   // random gap, then hold the item until the transfer happens
   task automatic offer_transfer(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                 input logic [PRIO_IN_W-1:0] prio);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_requester_id <= id;
      req_priority_req <= prio;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
   endtask

   task automatic issue_lock_event(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                   input logic [PRIO_IN_W-1:0] prio);
      rsp_type outcome;
      offer_transfer(cmd, id, prio);
      if (predict_lock_event(cmd, id, prio, outcome)) pending_outcomes.push_back(outcome);
   endtask

   // weights in percent; ticks fill the rest up to 97, a few undefined commands
   task automatic issue_random(input int unsigned req_w, input int unsigned rel_w);
      int unsigned pick;
      logic [CMD_W-1:0] cmd;
      pick = $urandom_range(99);
      if (pick < req_w) cmd = CMD_REQUEST;
      else if (pick < req_w + rel_w) cmd = CMD_RELEASE;
      else if (pick < 97) cmd = CMD_TICK;
      else cmd = CMD_UNDEFINED;
      issue_lock_event(cmd, ID_W'($urandom_range(255)), PRIO_IN_W'($urandom_range(3)));
   endtask

   // sender pauses until every predicted result is back and the block is quiet
   task automatic settle_outcomes();
      int unsigned spin;
      spin = 0;
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0 && spin < DRAIN_LIMIT) begin
         @(posedge clock);
         spin++;
      end
      if (pending_outcomes.size() != 0) begin
         flag_error($sformatf("%0d results never arrived", pending_outcomes.size()));
         pending_outcomes.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [ID_W-1:0]      id;
      logic [PRIO_IN_W-1:0] prio;
      logic                 typed;      // expectation written in the row
      logic                 gives_rsp;  // typed row yields a result
      rsp_type              rsp;
   } directed_row_type;

   // directed opening; untyped rows take their result from the predictor
   directed_row_type directed_script [25] = '{
      // nothing held after reset: release refused
      '{CMD_RELEASE,   8'h00, 2'd0, 1'b1, 1'b1, '{ST_NO_HOLDER, 8'h00, 32'd0, 5'd0}},
      // undefined command and a tick give no result
      '{CMD_UNDEFINED, 8'hff, 2'd3, 1'b1, 1'b0, '0},
      '{CMD_TICK,      8'h00, 2'd0, 1'b1, 1'b0, '0},
      // free lock: immediate grant with zero wait
      '{CMD_REQUEST,   8'h00, 2'd3, 1'b1, 1'b1, '{ST_GRANTED, 8'h00, 32'd0, 5'd1}},
      // lock held: requests queue silently
      '{CMD_REQUEST,   8'hff, 2'd0, 1'b1, 1'b0, '0},
      '{CMD_TICK,      8'h00, 2'd0, 1'b0, 1'b0, '0},
      '{CMD_TICK,      8'h00, 2'd0, 1'b0, 1'b0, '0},
      '{CMD_REQUEST,   8'h55, 2'd3, 1'b0, 1'b0, '0},
      '{CMD_REQUEST,   8'haa, 2'd1, 1'b0, 1'b0, '0},
      // same level as an earlier waiter: goes behind it
      '{CMD_REQUEST,   8'h12, 2'd0, 1'b0, 1'b0, '0},
      '{CMD_TICK,      8'h00, 2'd0, 1'b0, 1'b0, '0},
      // hand-overs in priority order
      '{CMD_RELEASE,   8'h00, 2'd0, 1'b0, 1'b0, '0},
      '{CMD_RELEASE,   8'h00, 2'd0, 1'b0, 1'b0, '0},
      '{CMD_RELEASE,   8'h00, 2'd0, 1'b0, 1'b0, '0},
      '{CMD_RELEASE,   8'h00, 2'd0, 1'b0, 1'b0, '0},
      // empty queue: lock freed without a result
      '{CMD_RELEASE,   8'h00, 2'd0, 1'b1, 1'b0, '0},
      '{CMD_UNDEFINED, 8'h00, 2'd0, 1'b1, 1'b0, '0},
      '{CMD_RELEASE,   8'h00, 2'd0, 1'b1, 1'b1, '{ST_NO_HOLDER, 8'h00, 32'd0, 5'd0}},
      '{CMD_REQUEST,   8'h80, 2'd2, 1'b1, 1'b1, '{ST_GRANTED, 8'h80, 32'd0, 5'd1}},
      '{CMD_REQUEST,   8'h01, 2'd2, 1'b0, 1'b0, '0},
      '{CMD_REQUEST,   8'h7f, 2'd3, 1'b0, 1'b0, '0},
      '{CMD_TICK,      8'h00, 2'd0, 1'b0, 1'b0, '0},
      '{CMD_RELEASE,   8'h00, 2'd0, 1'b0, 1'b0, '0},
      '{CMD_RELEASE,   8'h00, 2'd0, 1'b0, 1'b0, '0},
      '{CMD_RELEASE,   8'h00, 2'd0, 1'b1, 1'b0, '0}
   };

   initial begin
      rsp_type     outcome;
      bit          has_rsp;
      int unsigned phase;
      int unsigned n;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling
      foreach (directed_script[r]) begin
         offer_transfer(directed_script[r].cmd, directed_script[r].id,
                        directed_script[r].prio);
         has_rsp = predict_lock_event(directed_script[r].cmd, directed_script[r].id,
                                      directed_script[r].prio, outcome);
         if (directed_script[r].typed) begin
            if (directed_script[r].gives_rsp) pending_outcomes.push_back(directed_script[r].rsp);
         end else if (has_rsp) begin
            pending_outcomes.push_back(outcome);
         end
      end
      settle_outcomes();

      // four idling phases; fill and drain bias alternates so the queue
      // swings between empty and full (full requests get rejected)
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 77; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 77; end
            default: begin send_idle_pct = 26; rsp_stall_pct = 26; end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ((n / BIAS_BLOCK) % 2 == 0) issue_random(60, 20);
            else issue_random(20, 60);
         end
         settle_outcomes();

         if (phase == 0) begin
            // receiver holds off while the sender keeps offering: results back up
            // and the block has to stall its input
            fork
               hold_receiver(HOLD_CYCLES);
            join_none
            for (n = 0; n < PRESSURE_ITEMS; n++) issue_random(45, 45);
            settle_outcomes();
         end
      end

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      settle_outcomes();

      if (error_count == 0) begin
         $display("priority_ordered_lock_arbiter_tb: done, clean");
      end else begin
         $display("priority_ordered_lock_arbiter_tb: done, errors");
      end
      $finish;
   end

   // safety net well above the slowest legal run
   initial begin
      #10_000_000;
      $display("priority_ordered_lock_arbiter_tb: done, errors");
      $finish;
   end

endmodule
